/* hdl/ssf_pkg.sv */
// Shared types, constants and helpers for the scan sensor framer/stepper.
// No dependencies; imported by every module under hdl/.
`default_nettype none

package ssf_pkg;

    localparam int LIDAR_W  = 12;
    localparam int ECHO_W   = 16;
    localparam int SONAR_W  = 9;    // echo bits carried in the frame
    localparam int POS_W    = 7;
    localparam int PHASE_W  = 3;
    localparam int CYCLE_W  = 4;
    localparam int COIL_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_CYCLES  = 2'd1;

    localparam logic [CYCLE_W-1:0] SWEEP_CYCLES_RST = 4'd9;

    localparam logic [PHASE_W-1:0] PHASE_FIRST = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_LAST  = 3'd7;

    // One framing word handed from front to back
    typedef struct packed {
        logic                 filt;
        logic [SONAR_W-1:0]   sonar;
        logic [LIDAR_W-1:0]   lidar;
    } t_q_entry;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Half-step coil drive per phase
    function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] ph);
        logic [COIL_W-1:0] c;
        case (ph)
            3'd0:    c = 4'd10;
            3'd1:    c = 4'd8;
            3'd2:    c = 4'd9;
            3'd3:    c = 4'd1;
            3'd4:    c = 4'd5;
            3'd5:    c = 4'd4;
            3'd6:    c = 4'd6;
            3'd7:    c = 4'd2;
            default: c = 4'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* hdl/ssf_front.sv */
// Front end: takes input words, pairs and averages them when filtering.
// Depends on ssf_pkg; pushes framing words into ssf_queue.
`default_nettype none

module ssf_front
    import ssf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic               i_filter_enable,
    input  wire logic [LIDAR_W-1:0] i_lidar_sample,
    input  wire logic [ECHO_W-1:0]  i_echo_width,
    output      logic               o_push,
    output      t_q_entry           o_entry
);

    logic               r_pending;
    logic [LIDAR_W-1:0] r_lidar_held;
    logic [ECHO_W-1:0]  r_echo_held;
    logic               hold_now;
    logic [LIDAR_W:0]   lidar_sum;
    logic [ECHO_W:0]    echo_sum;
    logic [LIDAR_W-1:0] lidar_sel;
    logic [ECHO_W-1:0]  echo_sel;

    assign hold_now  = i_filter_enable && !r_pending;
    assign lidar_sum = {1'b0, r_lidar_held} + {1'b0, i_lidar_sample};
    assign echo_sum  = {1'b0, r_echo_held} + {1'b0, i_echo_width};

    always_comb begin
        if (i_filter_enable) begin
            lidar_sel = lidar_sum[LIDAR_W:1];
            echo_sel  = echo_sum[ECHO_W:1];
        end else begin
            lidar_sel = i_lidar_sample;
            echo_sel  = i_echo_width;
        end
    end

    assign o_push        = i_accept && !hold_now;
    assign o_entry.filt  = i_filter_enable;
    assign o_entry.sonar = echo_sel[SONAR_W-1:0];
    assign o_entry.lidar = lidar_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (i_accept) begin
            r_pending <= hold_now;
        end
    end

    // held sample only matters while r_pending is set
    always_ff @(posedge i_clk) begin
        if (i_accept && hold_now) begin
            r_lidar_held <= i_lidar_sample;
            r_echo_held  <= i_echo_width;
        end
    end

endmodule

`default_nettype wire

/* hdl/ssf_queue.sv */
// Small register FIFO between front and back.
// Depends on ssf_pkg for the entry and status types.
`default_nettype none

module ssf_queue
    import ssf_pkg::*;
#(
    parameter int DEPTH = 4     // power of two, 2 or more
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_q_entry  i_entry,
    input  wire logic      i_pop,
    output t_q_entry       o_entry,
    output t_q_status      o_status
);

    localparam int AW = $clog2(DEPTH);

    t_q_entry       r_mem [DEPTH];
    logic [AW:0]    r_wr_ptr;
    logic [AW:0]    r_rd_ptr;
    logic [AW:0]    n_wr_ptr;
    logic [AW:0]    n_rd_ptr;

    assign o_status.empty = (r_wr_ptr == r_rd_ptr);
    assign o_status.full  = (r_wr_ptr[AW] != r_rd_ptr[AW]) &&
                            (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]);
    assign o_entry = r_mem[r_rd_ptr[AW-1:0]];

    assign n_wr_ptr = r_wr_ptr + (AW+1)'(1);
    assign n_rd_ptr = r_rd_ptr + (AW+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_entry;
        end
    end

endmodule

`default_nettype wire

/* hdl/ssf_back.sv */
// Back end: stepper sweep, frame packing and the output register.
// Depends on ssf_pkg; pops framing words from ssf_queue.
`default_nettype none

module ssf_back
    import ssf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [CYCLE_W-1:0] i_sweep_cycles,
    input  wire t_q_entry           i_entry,
    input  wire t_q_status          i_q_status,
    output      logic               o_pop,
    output      logic               o_valid,
    input  wire logic               i_stall,
    output      logic [POS_W-1:0]   o_byte0,
    output      logic [7:0]         o_byte1,
    output      logic [7:0]         o_byte2,
    output      logic [7:0]         o_byte3,
    output      logic [COIL_W-1:0]  o_coil
);

    logic               r_valid;
    logic [PHASE_W-1:0] r_phase;
    logic               r_reverse;
    logic [CYCLE_W-1:0] r_cycles;
    logic [POS_W-1:0]   r_pos;
    logic [PHASE_W-1:0] n_phase;
    logic               n_reverse;
    logic [CYCLE_W-1:0] n_cycles;
    logic [POS_W-1:0]   n_pos;
    logic [7:0]         b1;
    logic [7:0]         b2;
    logic [7:0]         b3;

    assign o_pop = !i_q_status.empty && (!r_valid || !i_stall);

    // one half-step, then the sweep-end checks in order
    always_comb begin
        n_phase   = r_phase;
        n_cycles  = r_cycles;
        n_reverse = r_reverse;
        if (!r_reverse) begin
            n_pos = r_pos + POS_W'(1);
            if (r_phase == PHASE_LAST) begin
                n_phase  = PHASE_FIRST;
                n_cycles = r_cycles + CYCLE_W'(1);
            end else begin
                n_phase = r_phase + PHASE_W'(1);
            end
        end else begin
            n_pos = r_pos - POS_W'(1);
            if (r_phase == PHASE_FIRST) begin
                n_phase  = PHASE_LAST;
                n_cycles = r_cycles - CYCLE_W'(1);
            end else begin
                n_phase = r_phase - PHASE_W'(1);
            end
        end
        if (n_cycles == i_sweep_cycles && !n_reverse) begin
            n_reverse = 1'b1;
            n_phase   = PHASE_LAST;
        end
        if (n_cycles == '0 && n_reverse) begin
            n_reverse = 1'b0;
            n_phase   = PHASE_FIRST;
        end
    end

    always_comb begin
        b1 = {1'b1, i_entry.sonar[8:2]};
        if (i_entry.filt) begin
            b1[7:6] = 2'b11;
        end
        b2 = {1'b1, i_entry.sonar[1:0], i_entry.lidar[11:7]};
        b3 = {1'b1, i_entry.lidar[6:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_phase   <= PHASE_FIRST;
            r_reverse <= 1'b0;
            r_cycles  <= '0;
            r_pos     <= '0;
        end else begin
            if (o_pop) begin
                r_valid   <= 1'b1;
                r_phase   <= n_phase;
                r_reverse <= n_reverse;
                r_cycles  <= n_cycles;
                r_pos     <= n_pos;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_byte0 <= r_pos;
            o_byte1 <= b1;
            o_byte2 <= b2;
            o_byte3 <= b3;
            o_coil  <= coil_of(r_phase);
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* hdl/scan_sensor_framer_stepper.sv */
// Top level of the scan sensor framer with stepper sweep.
// Depends on ssf_pkg, ssf_front, ssf_queue and ssf_back.
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  -------------------------------
//  in       input      i_in_valid / o_in_stall   i_lidar_sample, i_echo_width
//  out      output     o_out_valid / i_out_stall o_frame_byte0..3, o_coil_pattern
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One word per cycle in and out while neither side is stalled. A framing word
// is written into the queue at the accepting edge and moves into the output
// register when the back pops it; a word held as the first of a filter pair
// makes no output. The queue of QUEUE_DEPTH entries lets the front keep taking
// words while the output stalls; o_in_stall rises only when the queue is full.
// Reset is synchronous, active low, and clears the pair flag, queue pointers,
// stepper and config registers.
`default_nettype none

module scan_sensor_framer_stepper
    import ssf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4   // power of two, 2 or more
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input words
    input  wire logic                 i_in_valid,
    output      logic                 o_in_stall,
    input  wire logic [LIDAR_W-1:0]   i_lidar_sample,
    input  wire logic [ECHO_W-1:0]    i_echo_width,
    // output words
    output      logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    output      logic [POS_W-1:0]     o_frame_byte0,
    output      logic [7:0]           o_frame_byte1,
    output      logic [7:0]           o_frame_byte2,
    output      logic [7:0]           o_frame_byte3,
    output      logic [COIL_W-1:0]    o_coil_pattern,
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output      logic                 o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic               r_filter_enable;
    logic [CYCLE_W-1:0] r_sweep_cycles;
    logic               in_accept;
    logic               push;
    logic               pop;
    t_q_entry           push_entry;
    t_q_entry           pop_entry;
    t_q_status          q_status;

    // Config registers: always ready, writes never touch datapath state.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_enable <= 1'b0;
            r_sweep_cycles  <= SWEEP_CYCLES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FILTER_ENABLE: r_filter_enable <= i_cfg_data[0];
                CFG_SWEEP_CYCLES:  r_sweep_cycles  <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // Front only stalls on a full queue, even for a word it will just hold.
    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid && !o_in_stall;

    ssf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_filter_enable (r_filter_enable),
        .i_lidar_sample  (i_lidar_sample),
        .i_echo_width    (i_echo_width),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    ssf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (pop_entry),
        .o_status (q_status)
    );

    // Back owns the stepper; it advances once per word it frames.
    ssf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sweep_cycles (r_sweep_cycles),
        .i_entry        (pop_entry),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_byte0        (o_frame_byte0),
        .o_byte1        (o_frame_byte1),
        .o_byte2        (o_frame_byte2),
        .o_byte3        (o_frame_byte3),
        .o_coil         (o_coil_pattern)
    );

    // A pushed word is in the queue or already framed on the next cycle.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (!q_status.empty || o_out_valid))
        else $error("pushed word lost between front and back");

    // Queue can never look both full and empty.
    a_q_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue status inconsistent");

    // Coil drive on a valid output is always a real half-step pattern.
    a_coil_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_coil_pattern == 4'd10 || o_coil_pattern == 4'd8 ||
                         o_coil_pattern == 4'd9  || o_coil_pattern == 4'd1 ||
                         o_coil_pattern == 4'd5  || o_coil_pattern == 4'd4 ||
                         o_coil_pattern == 4'd6  || o_coil_pattern == 4'd2))
        else $error("illegal coil pattern");

endmodule

`default_nettype wire
